[hw/rtl/bfdh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants for the double-hash Bloom filter block.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned BIDX_W    = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HCNT_W    = 3;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned ROT_RIGHT = 34;

  localparam logic [HCNT_W-1:0] HCNT_RST = 3'd4;
  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd12;

  // register indexes on the config port
  typedef enum logic {
    REG_HASH_COUNT = 1'b0,
    REG_SIZE_LOG2  = 1'b1
  } reg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_PROBE = 3'd1,
    OP_MERGE = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key_hash;
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
  } bfdh_in_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] byte_out;
  } bfdh_out_t;

  typedef enum logic [1:0] {
    ADDR_HASH  = 2'd0,
    ADDR_BIDX  = 2'd1,
    ADDR_SWEEP = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_OR_MASK = 2'd0,
    WD_OR_BYTE = 2'd1,
    WD_ZERO    = 2'd2
  } wdata_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_HIT  = 2'd1,
    RES_BYTE = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       ram_en;
    logic       ram_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       res_ld;
    res_sel_e   res_sel;
  } bfdh_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic in_range;
    logic last;
    logic bit_set;
    logic sweep_last;
  } bfdh_sts_t;

endpackage

[hw/rtl/bloom_filter_double_hash_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top
// Bloom filter over a byte-wide bit store, double-hash probing, APB config.
// ----------------------------------------------------------------------------
// Usage:
//   Command word on req: issued when start is high and busy is low. Ops are
//   add key, probe key, merge byte, read byte, clear; codes 5..7 do nothing.
//   Every command returns one result word on rsp_o, valid for exactly one
//   cycle while done_o is high. The receiver cannot stall, so nothing waits.
// Sequence per op, single-port RAM bound:
//   add           k probes, k = min(hash_count, MAX_HASHES);
//                 each probe is a RAM read (S_RD) then a check/write (S_CHK)
//   probe         j probes, j = probes until the first clear bit (j <= k)
//   merge / read  in range read, then merge write-back; else no RAM access
//   clear         all MAX_BYTES bytes, one byte zeroed per cycle
//   zero k / unknown op: no RAM access
//   busy drops with done_o, so the next word can issue in that cycle.
// Reset: busy stays high while the store is swept to zero; config
//   writes are taken during the sweep. hash_count resets to 4,
//   size_log2_bytes to 12.
// Config: reg 0 hash_count at 0x0, reg 1 size_log2_bytes at 0x4. Write only
//   while idle.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top import bfdh_pkg::*; #(
  parameter int unsigned MAX_BYTES  = 4096,
  parameter int unsigned MAX_HASHES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  bfdh_in_t    req_i,
  // result channel
  output logic        done_o,
  output bfdh_out_t   rsp_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [HCNT_W-1:0] hash_count_q, hash_count_d;
  logic [SIZE_W-1:0] size_log2_q, size_log2_d;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;
  bfdh_cmd_t         cmd;
  bfdh_sts_t         sts;

  // register file: word address taken from paddr[2], low bits ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    hash_count_d = hash_count_q;
    size_log2_d  = size_log2_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HASH_COUNT: hash_count_d = pwdata[HCNT_W-1:0];
        REG_SIZE_LOG2:  size_log2_d  = pwdata[SIZE_W-1:0];
        default:        hash_count_d = hash_count_q;
      endcase
    end
    unique case (cfg_idx)
      REG_HASH_COUNT: prdata = 32'(hash_count_q);
      REG_SIZE_LOG2:  prdata = 32'(size_log2_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= HCNT_RST;
      size_log2_q  <= SIZE_RST;
    end else begin
      hash_count_q <= hash_count_d;
      size_log2_q  <= size_log2_d;
    end
  end

  // sequencer: decides per cycle what the datapath does
  bfdh_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (req_i.op),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // hash stepping, filter RAM, result register
  bfdh_dp #(
    .MAX_BYTES  (MAX_BYTES),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .hash_count_i (hash_count_q),
    .size_log2_i  (size_log2_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

endmodule

[hw/rtl/bfdh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bfdh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_dp
// Datapath: hash stepping, address and write-data muxing, sweep counter,
// filter RAM and result register.
// ----------------------------------------------------------------------------
module bfdh_dp import bfdh_pkg::*; #(
  parameter int unsigned MAX_BYTES  = 4096,
  parameter int unsigned MAX_HASHES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfdh_in_t          req_i,
  input  logic [HCNT_W-1:0] hash_count_i,
  input  logic [SIZE_W-1:0] size_log2_i,
  input  bfdh_cmd_t         cmd_i,
  output bfdh_sts_t         sts_o,
  output bfdh_out_t         rsp_o
);

  localparam int unsigned AW       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned LIM_LOG2 = $clog2(MAX_BYTES + 1) - 1;
  localparam int unsigned KW       = $clog2(MAX_HASHES + 1);
  localparam int unsigned ZW       = (AW > BIDX_W) ? AW : BIDX_W;

  logic [KEY_W-1:0]  h_q, h_d;
  logic [KEY_W-1:0]  delta_q, delta_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic [BYTE_W-1:0] bval_q, bval_d;
  logic [KW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  bfdh_out_t         res_q, res_d;

  logic [SIZE_W-1:0] act_log2;
  logic [KW-1:0]     k_act;
  logic [AW-1:0]     idx_mask;
  logic [AW-1:0]     addr_hash;
  logic [ZW-1:0]     bidx_ext;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] bit_mask;

  // size saturated to the largest power of two in store, k to MAX_HASHES
  always_comb begin
    if (32'(size_log2_i) > LIM_LOG2) begin
      act_log2 = SIZE_W'(LIM_LOG2);
    end else begin
      act_log2 = size_log2_i;
    end
    if (32'(hash_count_i) > MAX_HASHES) begin
      k_act = KW'(MAX_HASHES);
    end else begin
      k_act = KW'(hash_count_i);
    end
  end

  assign idx_mask  = ~({AW{1'b1}} << act_log2);
  assign addr_hash = h_q[3 +: AW] & idx_mask;
  assign bidx_ext  = ZW'(bidx_q);
  assign bit_mask  = BYTE_W'(1) << h_q[2:0];

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_HASH:  ram_addr = addr_hash;
      ADDR_BIDX:  ram_addr = bidx_ext[AW-1:0];
      ADDR_SWEEP: ram_addr = sweep_q;
      default:    ram_addr = sweep_q;
    endcase
    unique case (cmd_i.wdata_sel)
      WD_OR_MASK: ram_wdata = ram_rdata | bit_mask;
      WD_OR_BYTE: ram_wdata = ram_rdata | bval_q;
      WD_ZERO:    ram_wdata = '0;
      default:    ram_wdata = '0;
    endcase
  end

  bfdh_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.ram_en),
    .we_i    (cmd_i.ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    h_d     = h_q;
    delta_d = delta_q;
    bidx_d  = bidx_q;
    bval_d  = bval_q;
    cnt_d   = cnt_q;
    sweep_d = sweep_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      h_d     = req_i.key_hash;
      delta_d = {req_i.key_hash[ROT_RIGHT-1:0], req_i.key_hash[KEY_W-1:ROT_RIGHT]};
      bidx_d  = req_i.byte_index;
      bval_d  = req_i.byte_value;
      cnt_d   = '0;
    end else if (cmd_i.step) begin
      h_d   = h_q + delta_q;
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.sweep_clr) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_inc) begin
      sweep_d = sweep_q + 1'b1;
    end
    if (cmd_i.res_ld) begin
      unique case (cmd_i.res_sel)
        RES_ZERO: res_d = '0;
        RES_HIT:  res_d = '{hit: 1'b1, byte_out: '0};
        RES_BYTE: res_d = '{hit: 1'b0, byte_out: ram_rdata};
        default:  res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sweep_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q     <= h_d;
    delta_q <= delta_d;
    bidx_q  <= bidx_d;
    bval_q  <= bval_d;
    res_q   <= res_d;
  end

  assign sts_o.k_zero     = (k_act == '0);
  assign sts_o.in_range   = ((req_i.byte_index >> act_log2) == '0);
  assign sts_o.last       = (KW'(cnt_q + 1'b1) == k_act);
  assign sts_o.bit_set    = ((ram_rdata & bit_mask) != '0);
  assign sts_o.sweep_last = (sweep_q == AW'(MAX_BYTES - 1));
  assign rsp_o            = res_q;

endmodule

[hw/rtl/bfdh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Controller FSM: sequences RAM read/modify/write per probe, clear sweeps,
// and the result strobe.
// ----------------------------------------------------------------------------
module bfdh_ctrl import bfdh_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  input  bfdh_sts_t       sts_i,
  output bfdh_cmd_t       cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_CLR  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  logic            done_q, done_d;
  logic            is_key;

  assign is_key = (op_q == OP_ADD) || (op_q == OP_PROBE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{addr_sel: ADDR_SWEEP, wdata_sel: WD_ZERO, res_sel: RES_ZERO, default: 1'b0};
    unique case (state_q)
      S_INIT: begin
        cmd_o.ram_en    = 1'b1;
        cmd_o.ram_we    = 1'b1;
        cmd_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          op_d = op_i;
          unique case (op_i)
            OP_ADD, OP_PROBE: begin
              cmd_o.load = 1'b1;
              if (sts_i.k_zero) begin
                cmd_o.res_ld  = 1'b1;
                cmd_o.res_sel = (op_i == OP_PROBE) ? RES_HIT : RES_ZERO;
              end else begin
                state_d = S_RD;
              end
            end
            OP_MERGE, OP_READ: begin
              cmd_o.load = 1'b1;
              if (sts_i.in_range) begin
                state_d = S_RD;
              end else begin
                cmd_o.res_ld = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd_o.sweep_clr = 1'b1;
              state_d         = S_CLR;
            end
            default: begin
              cmd_o.res_ld = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.ram_en   = 1'b1;
        cmd_o.addr_sel = is_key ? ADDR_HASH : ADDR_BIDX;
        state_d        = S_CHK;
      end
      S_CHK: begin
        cmd_o.addr_sel = is_key ? ADDR_HASH : ADDR_BIDX;
        state_d        = S_IDLE;
        unique case (op_q)
          OP_ADD: begin
            cmd_o.ram_en    = 1'b1;
            cmd_o.ram_we    = 1'b1;
            cmd_o.wdata_sel = WD_OR_MASK;
            cmd_o.step      = 1'b1;
            if (sts_i.last) begin
              cmd_o.res_ld = 1'b1;
            end else begin
              state_d = S_RD;
            end
          end
          OP_PROBE: begin
            cmd_o.step = 1'b1;
            if (!sts_i.bit_set) begin
              cmd_o.res_ld = 1'b1;
            end else if (sts_i.last) begin
              cmd_o.res_ld  = 1'b1;
              cmd_o.res_sel = RES_HIT;
            end else begin
              state_d = S_RD;
            end
          end
          OP_MERGE: begin
            cmd_o.ram_en    = 1'b1;
            cmd_o.ram_we    = 1'b1;
            cmd_o.wdata_sel = WD_OR_BYTE;
            cmd_o.res_ld    = 1'b1;
          end
          OP_READ: begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = RES_BYTE;
          end
          default: begin
            cmd_o.res_ld = 1'b1;
          end
        endcase
      end
      S_CLR: begin
        cmd_o.ram_en    = 1'b1;
        cmd_o.ram_we    = 1'b1;
        cmd_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    done_d = cmd_o.res_ld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
